[rtl/core/tnk_pkg.sv]
`timescale 1ns / 1ps

package tnk_pkg;

	localparam int KEY_W     = 32;
	localparam int PAY_W     = 32;
	localparam int DEPTH_DEF = 128;

	// One kept entry: signed key and the payload that travels with it.
	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [PAY_W-1:0]        payload;
	} entry_t;

endpackage

[rtl/core/top_n_keys_with_payload_core.sv]
`timescale 1ns / 1ps
// A result appears on the master side in the cycle after its request is taken.
// One request per cycle unless stalled; all cells compare the key in parallel.
// A result waiting on the master side stalls intake only while m_tready is low.
// Reset (arst_n low, asynchronous): every cell holds key -1 and payload all ones,
// and the output register is emptied. No clearing pass is needed.

module top_n_keys_with_payload_core #(
	parameter int DEPTH = tnk_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] key (signed), [63:32] payload
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [31:0] out_payload
);
	import tnk_pkg::*;

	logic                    accept;
	logic signed [KEY_W-1:0] in_key;
	logic [PAY_W-1:0]        in_payload;

	// Cell 0 holds the smallest kept key; keys ascend toward the far end.
	entry_t           cell_entry [DEPTH];
	logic [DEPTH-1:0] cell_le;

	logic             out_valid_q;
	logic [PAY_W-1:0] out_payload_q;

	assign in_key     = s_tdata[KEY_W-1:0];
	assign in_payload = s_tdata[KEY_W+PAY_W-1:KEY_W];

	// The output register frees up in the same cycle it is drained.
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	// The le flags form a run of ones from cell 0 upward since keys are sorted.
	// A key below cell 0 leaves every flag low, so no cell moves: that is a reject.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t nbr_entry;
		logic   nbr_le;

		if (i == DEPTH - 1) begin : g_top
			assign nbr_entry = '1;
			assign nbr_le    = 1'b0;
		end else begin : g_mid
			assign nbr_entry = cell_entry[i+1];
			assign nbr_le    = cell_le[i+1];
		end

		tnk_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (accept),
			.in_key     (in_key),
			.in_payload (in_payload),
			.nbr_entry  (nbr_entry),
			.nbr_le     (nbr_le),
			.entry      (cell_entry[i]),
			.le         (cell_le[i])
		);
	end

	// Return the evicted smallest payload, or the request's own on a reject.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_payload_q <= cell_le[0] ? cell_entry[0].payload : in_payload;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_payload_q;

endmodule

[rtl/core/tnk_cell.sv]
`timescale 1ns / 1ps

module tnk_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic signed [tnk_pkg::KEY_W-1:0] in_key,
	input  logic [tnk_pkg::PAY_W-1:0]     in_payload,
	input  tnk_pkg::entry_t               nbr_entry,
	input  logic                          nbr_le,
	output tnk_pkg::entry_t               entry,
	output logic                          le
);
	import tnk_pkg::*;

	entry_t entry_q;

	// Kept key at or below the incoming key.
	assign le    = (entry_q.key <= in_key);
	assign entry = entry_q;

	// Shift down when the upper neighbor also sits at or below the key,
	// take the new entry at the top of the run, hold otherwise.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '1;
		end else if (en) begin
			if (nbr_le) begin
				entry_q <= nbr_entry;
			end else if (le) begin
				entry_q.key     <= in_key;
				entry_q.payload <= in_payload;
			end
		end
	end

endmodule

[rtl/core/tnk_chk.sv]
`timescale 1ns / 1ps

module tnk_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// A stalled result holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// Every taken request yields a result in the next cycle.
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("request produced no result");

	// No result appears without a request behind it.
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid || m_tready) && !(s_tvalid && s_tready) |=> !m_tvalid)
		else $error("result without request");

	// Intake is open whenever the output side can take a result.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("intake ready mismatch");

endmodule

bind top_n_keys_with_payload_core tnk_chk u_tnk_chk (.*);
